>>> rtl/laman_pebble_game_oracle_defines.svh
// assertion macros for the pebble game block
`ifndef LAMAN_PEBBLE_GAME_ORACLE_DEFINES_SVH
`define LAMAN_PEBBLE_GAME_ORACLE_DEFINES_SVH

// implication checked at every clock edge outside reset
`define LPG_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication checked outside reset
`define LPG_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

>>> rtl/lpgo_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package lpgo_pkg;
  localparam logic [1:0] CMD_CLEAR  = 2'd0;
  localparam logic [1:0] CMD_TEST   = 2'd1;
  localparam logic [1:0] CMD_INSERT = 2'd2;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_LOOP  = 2'd1;
  localparam logic [1:0] ST_RANGE = 2'd2;
  localparam logic [1:0] ST_FULL  = 2'd3;
endpackage
`default_nettype wire

>>> rtl/lpgo_seq.sv
`timescale 1ns / 1ps
`default_nettype none
module lpgo_seq import lpgo_pkg::*; #(
  parameter int MAX_VERTICES = 64,
  parameter int MAX_EDGES    = 128
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [1:0]  in_command,
  input  wire logic [5:0]  in_vertex_u,
  input  wire logic [5:0]  in_vertex_v,
  input  wire logic [6:0]  n_act,
  output logic             out_strobe,
  output logic             out_independent,
  output logic             out_inserted,
  output logic [63:0]      out_reach_mask,
  output logic [7:0]       out_stored_edges,
  output logic [1:0]       out_status
);
  localparam int EW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam int VW = $clog2(MAX_VERTICES);
  localparam int CW = $clog2(MAX_EDGES + 1);

  typedef enum logic [17:0] {
    S_IDLE   = 18'h00001,
    S_CLR    = 18'h00002,
    S_LDU    = 18'h00004,
    S_LDV    = 18'h00008,
    S_LDW    = 18'h00010,
    S_GATHER = 18'h00020,
    S_POP    = 18'h00040,
    S_POPRD  = 18'h00080,
    S_POPCHK = 18'h00100,
    S_SCAN   = 18'h00200,
    S_SCANW  = 18'h00400,
    S_REVA   = 18'h00800,
    S_REVW   = 18'h01000,
    S_REVE   = 18'h02000,
    S_REV    = 18'h04000,
    S_REACH  = 18'h08000,
    S_REACHW = 18'h10000,
    S_DONE   = 18'h20000
  } state_t;
  state_t state_r;

  // edge and vertex stores
  logic [5:0]    tail_m [MAX_EDGES];
  logic [5:0]    head_m [MAX_EDGES];
  logic [EW-1:0] arr_m  [MAX_VERTICES];
  logic [5:0]    stk_m  [MAX_VERTICES];
  logic [1:0]    peb_m  [MAX_VERTICES];

  logic [1:0]  cmd_r;
  logic [5:0]  u_r, v_r, s_r, o_r, x_r;
  logic [CW-1:0] tot_r;
  logic [63:0] vis_r;
  logic [VW:0] sp_r;
  logic [EW:0] id_r;
  logic        side_r, grew_r, tried_u_r;
  logic [5:0]  et_q, eh_q, stk_q;
  logic [EW-1:0] arr_q;
  logic [VW-1:0] steps_r;
  logic [1:0]  peb_q, pu_r, pv_r;
  logic [6:0]  n_r;
  logic [VW-1:0] clr_r;
  logic        init_r;

  wire [EW-1:0] id_i = id_r[EW-1:0];
  wire [3:0] pu = {2'b0, pu_r};
  wire [3:0] pv = {2'b0, pv_r};
  // pebble store read address: endpoints while loading, else the popped vertex
  wire [VW-1:0] peb_a = (state_r == S_LDU) ? u_r[VW-1:0] :
                        (state_r == S_LDV) ? v_r[VW-1:0] : stk_q[VW-1:0];

  assign busy = (state_r != S_IDLE);

  always_ff @(posedge clk) begin
    et_q  <= tail_m[id_i];
    eh_q  <= head_m[id_i];
    stk_q <= stk_m[sp_r[VW-1:0] - 1'b1];
    arr_q <= arr_m[x_r[VW-1:0]];
    peb_q <= peb_m[peb_a];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_CLR;
      init_r     <= 1'b1;
      clr_r      <= '0;
      n_r        <= 7'(MAX_VERTICES);
      tot_r      <= '0;
      out_strobe <= 1'b0;
    end else begin
      out_strobe <= (state_r == S_DONE);
      unique case (state_r)
        S_IDLE: begin
          tried_u_r <= 1'b0; side_r <= 1'b0;
          if (start) begin
            cmd_r <= in_command; u_r <= in_vertex_u; v_r <= in_vertex_v;
            out_independent <= 1'b0; out_inserted <= 1'b0;
            out_reach_mask <= '0;
            if (in_command == CMD_CLEAR) begin
              out_status <= ST_OK;
              n_r <= n_act; clr_r <= '0; tot_r <= '0;
              state_r <= S_CLR;
            end else if (in_command == CMD_TEST || in_command == CMD_INSERT) begin
              if ({1'b0, in_vertex_u} >= n_act || {1'b0, in_vertex_v} >= n_act) begin
                out_status <= ST_RANGE; state_r <= S_DONE;
              end else if (in_vertex_u == in_vertex_v) begin
                out_status <= ST_LOOP; state_r <= S_DONE;
              end else if (in_command == CMD_INSERT && tot_r >= CW'(MAX_EDGES)) begin
                out_status <= ST_FULL; state_r <= S_DONE;
              end else begin
                out_status <= ST_OK; state_r <= S_LDU;
              end
            end else begin
              out_status <= ST_OK; state_r <= S_DONE;
            end
          end
        end
        S_CLR: begin
          // one vertex per cycle, two pebbles below the count
          peb_m[clr_r] <= (7'(clr_r) < n_r) ? 2'd2 : 2'd0;
          clr_r <= clr_r + 1'b1;
          if (clr_r == VW'(MAX_VERTICES - 1)) begin
            init_r  <= 1'b0;
            state_r <= init_r ? S_IDLE : S_DONE;
          end
        end
        S_LDU: state_r <= S_LDV;
        S_LDV: begin
          pu_r <= peb_q; state_r <= S_LDW;
        end
        S_LDW: begin
          pv_r <= peb_q; state_r <= S_GATHER;
        end
        S_GATHER: begin
          // try u first, then v; tried_u tracks the current round
          if (pu + pv >= 4'd4) begin
            out_independent <= 1'b1;
            if (cmd_r == CMD_INSERT) begin
              pu_r <= pu_r - 2'd1;
              peb_m[u_r[VW-1:0]] <= pu_r - 2'd1;
              tail_m[tot_r[EW-1:0]] <= u_r;
              head_m[tot_r[EW-1:0]] <= v_r;
              tot_r <= tot_r + 1'b1;
              out_inserted <= 1'b1;
            end
            state_r <= S_DONE;
          end else if (!tried_u_r && pu < 4'd2) begin
            tried_u_r <= 1'b1; side_r <= 1'b0;
            s_r <= u_r; o_r <= v_r;
            vis_r <= 64'd1 << u_r; stk_m[0] <= u_r; sp_r <= (VW+1)'(1);
            state_r <= S_POP;
          end else if (pv < 4'd2 && (side_r == 1'b0 || !tried_u_r)) begin
            tried_u_r <= 1'b1; side_r <= 1'b1;
            s_r <= v_r; o_r <= u_r;
            vis_r <= 64'd1 << v_r; stk_m[0] <= v_r; sp_r <= (VW+1)'(1);
            state_r <= S_POP;
          end else begin
            vis_r <= (64'd1 << u_r) | (64'd1 << v_r);
            id_r <= '0; grew_r <= 1'b0;
            state_r <= S_REACH;
          end
        end
        S_POP: begin
          if (sp_r == '0) begin
            // search failed on this side
            if (side_r == 1'b0 && pv < 4'd2) begin
              tried_u_r <= 1'b1; side_r <= 1'b1; s_r <= v_r; o_r <= u_r;
              vis_r <= 64'd1 << v_r; stk_m[0] <= v_r; sp_r <= (VW+1)'(1);
            end else begin
              vis_r <= (64'd1 << u_r) | (64'd1 << v_r);
              id_r <= '0; grew_r <= 1'b0; state_r <= S_REACH;
            end
          end else state_r <= S_POPRD;
        end
        S_POPRD: state_r <= S_POPCHK;
        S_POPCHK: begin
          x_r <= stk_q; sp_r <= sp_r - 1'b1;
          if (stk_q != s_r && stk_q != o_r && peb_q != 2'd0) begin
            peb_m[stk_q[VW-1:0]] <= peb_q - 2'd1;
            if (side_r) pv_r <= pv_r + 2'd1;
            else pu_r <= pu_r + 2'd1;
            steps_r <= '0;
            state_r <= S_REVA;
          end else begin
            id_r <= '0; state_r <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (id_r >= tot_r[EW:0] || id_r >= (EW+1)'(MAX_EDGES)) state_r <= S_POP;
          else state_r <= S_SCANW;
        end
        S_SCANW: begin
          if (et_q == x_r && !vis_r[eh_q]) begin
            vis_r[eh_q] <= 1'b1;
            arr_m[eh_q[VW-1:0]] <= id_i;
            if (sp_r < (VW+1)'(MAX_VERTICES)) begin
              stk_m[sp_r[VW-1:0]] <= eh_q; sp_r <= sp_r + 1'b1;
            end
          end
          id_r <= id_r + 1'b1; state_r <= S_SCAN;
        end
        S_REVA: begin
          // arrival edge of x is read here, pebble count of s written back
          peb_m[s_r[VW-1:0]] <= side_r ? pv_r : pu_r;
          state_r <= S_REVW;
        end
        S_REVW: begin
          id_r <= {1'b0, arr_q}; state_r <= S_REVE;
        end
        S_REVE: state_r <= S_REV;
        S_REV: begin
          // flip edge, walk to its tail
          tail_m[id_i] <= eh_q; head_m[id_i] <= et_q;
          x_r <= et_q; steps_r <= steps_r + 1'b1;
          if (et_q == s_r || steps_r == VW'(MAX_VERTICES - 1)) begin
            tried_u_r <= 1'b0; side_r <= 1'b0; state_r <= S_GATHER;
          end else state_r <= S_REVA;
        end
        S_REACH: begin
          if (id_r >= tot_r[EW:0] || id_r >= (EW+1)'(MAX_EDGES)) begin
            if (grew_r) begin id_r <= '0; grew_r <= 1'b0; end
            else begin out_reach_mask <= vis_r; state_r <= S_DONE; end
          end else state_r <= S_REACHW;
        end
        S_REACHW: begin
          if (vis_r[et_q] && !vis_r[eh_q]) begin
            vis_r[eh_q] <= 1'b1; grew_r <= 1'b1;
          end
          id_r <= id_r + 1'b1; state_r <= S_REACH;
        end
        S_DONE: begin
          out_stored_edges <= 8'(tot_r);
          state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

>>> rtl/laman_pebble_game_oracle.sv
`timescale 1ns / 1ps
`default_nettype none
// steps: errors and unused commands go straight to the result, clear runs a pebble
//   clearing pass over every vertex; test and insert load both pebble counts, pop
//   vertices and scan stored edges, reverse the edges of a found path, run reach passes
// throughput: one item at a time, busy stays high until the result strobe
// reset: synchronous active low, empty table, count 64, then a clearing pass with busy
//   high gives every vertex two pebbles; the receiver cannot stall, out_strobe once
module laman_pebble_game_oracle import lpgo_pkg::*; #(
  parameter int MAX_VERTICES = 64,
  parameter int MAX_EDGES    = 128
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [1:0]  in_command,
  input  wire logic [5:0]  in_vertex_u,
  input  wire logic [5:0]  in_vertex_v,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [6:0]  cfg_vertex_count,
  output logic             out_strobe,
  output logic             out_independent,
  output logic             out_inserted,
  output logic [63:0]      out_reach_mask,
  output logic [7:0]       out_stored_edges,
  output logic [1:0]       out_status
);
  logic [6:0] vcount_r;
  logic [6:0] n_act;

  // config register, always writable
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) vcount_r <= 7'd64;
    else if (cfg_valid) vcount_r <= cfg_vertex_count;
  end

  // clamp count to 1..MAX_VERTICES
  always_comb begin
    n_act = vcount_r;
    if (n_act == 7'd0) n_act = 7'd1;
    if (n_act > 7'(MAX_VERTICES)) n_act = 7'(MAX_VERTICES);
  end

  lpgo_seq #(.MAX_VERTICES(MAX_VERTICES), .MAX_EDGES(MAX_EDGES)) u_seq (
    .clk, .rst_n, .start, .busy, .in_command, .in_vertex_u, .in_vertex_v,
    .n_act, .out_strobe, .out_independent, .out_inserted, .out_reach_mask,
    .out_stored_edges, .out_status
  );
endmodule
`default_nettype wire

>>> rtl/lpgo_checker.sv
`timescale 1ns / 1ps
`default_nettype none
`include "laman_pebble_game_oracle_defines.svh"
module lpgo_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       start,
  input wire logic       busy,
  input wire logic       out_strobe,
  input wire logic       out_independent,
  input wire logic       out_inserted,
  input wire logic [63:0] out_reach_mask
);
  `LPG_ASSERT_NXT(a_busy_after_start, clk, rst_n, start && !busy, busy)
  `LPG_ASSERT_IMP(a_ins_indep, clk, rst_n, out_strobe && out_inserted, out_independent)
  `LPG_ASSERT_IMP(a_mask_dep, clk, rst_n, out_strobe && out_independent,
    out_reach_mask == 64'd0)
  `LPG_ASSERT_NXT(a_strobe_idle, clk, rst_n, out_strobe, !out_strobe)
endmodule
bind laman_pebble_game_oracle lpgo_checker u_chk (.*);
`default_nettype wire
